// ----- rtl/bale_pkg.sv -----
// Shared operation codes, field widths and default sizing for the array list engine.
`timescale 1ns / 1ps

package bale_pkg;

    // Default number of list entries
    localparam int CAPACITY_DEF = 64;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int AT_W    = 6;
    localparam int COUNT_W = 7;

    // Packed stream widths
    localparam int S_TDATA_W = 40;  // position, word, padded to bytes
    localparam int S_TUSER_W = 8;   // op, padded to bytes
    localparam int M_TDATA_W = 48;  // ok, read_word, found_at, count, empty_res, padded

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

endpackage

// ----- rtl/bale_ram.sv -----
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bale_ram import bale_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = WORD_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bounded_array_list_engine.sv -----
// Top level of the bounded array list engine: request sequencer around the entry store.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Word layout (lowest bit first)
//  ---------+-----------+------------------------------------------------------------
//  s_       | in        | tuser: op[2:0]; tdata: position[6:0], word[38:7]
//  m_       | out       | tdata: ok[0], read_word[32:1], found_at[38:33],
//           |           |        count[45:39], empty_res[46]
//
//  Append, overwrite, clear and failed requests go straight to the final state; read
//  passes through a read wait; insert moves each entry from position upward, then writes
//  the word; remove reads the entry, then moves each entry above it down; find compares from
//  index 0. Via the single read port, each shift or compare step reads one entry per cycle.
//  Reset clears the count, the sequencer and the output valid; entry contents are not cleared.
//  A finished result holds in the output register until taken; a new word is accepted
//  while it waits, and the next result holds in the final state until the register frees.

module bounded_array_list_engine import bale_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[6:0], word[38:7], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // op[2:0], zero pad
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // ok, read_word, found_at, count, empty_res
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SHIFT_UP  = 3'd1;
    localparam logic [2:0] ST_INS_WR    = 3'd2;
    localparam logic [2:0] ST_READ_WAIT = 3'd3;
    localparam logic [2:0] ST_SHIFT_DN  = 3'd4;
    localparam logic [2:0] ST_SCAN      = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 ok_reg, ok_next;
    logic [WORD_W-1:0]    rd_reg, rd_next;
    logic [AW-1:0]        at_reg, at_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Entry store port signals
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_W-1:0]    mem_rdata;

    // Unpacked request fields
    logic [OP_W-1:0]      in_op;
    logic [POS_W-1:0]     in_pos;
    logic [WORD_W-1:0]    in_word;
    logic [CMPW-1:0]      pos_cmp;
    logic [CMPW-1:0]      fill_cmp;
    logic                 full;
    logic                 out_free;
    logic [CW:0]          idx_plus2;

    assign in_op    = s_tuser[OP_W-1:0];
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_word  = s_tdata[POS_W+WORD_W-1:POS_W];
    assign pos_cmp  = CMPW'(in_pos);
    assign fill_cmp = CMPW'(fill_reg);
    assign full     = (fill_reg == CW'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_plus2 = {1'b0, idx_reg} + (CW+1)'(2);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bale_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        ok_next       = ok_reg;
        rd_next       = rd_reg;
        at_next       = at_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = word_reg;
        mem_raddr     = '0;

        // drop the held result once taken; a new result below overrides
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = in_op;
                    pos_next   = AW'(in_pos);
                    word_next  = in_word;
                    ok_next    = 1'b0;
                    rd_next    = '0;
                    at_next    = '0;
                    state_next = ST_FINISH;
                    unique case (in_op)
                        OP_APPEND: begin
                            if (!full) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = in_word;
                                fill_next = fill_reg + CW'(1);
                                ok_next   = 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_cmp <= fill_cmp && !full) begin
                                if (pos_cmp == fill_cmp) begin
                                    state_next = ST_INS_WR;
                                end else begin
                                    // fetch the last entry; it moves up first
                                    mem_raddr  = AW'(fill_reg - CW'(1));
                                    idx_next   = fill_reg;
                                    state_next = ST_SHIFT_UP;
                                end
                            end
                        end
                        OP_OVERWRITE: begin
                            if (pos_cmp < fill_cmp) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(in_pos);
                                mem_wdata = in_word;
                                ok_next   = 1'b1;
                            end
                        end
                        OP_REMOVE, OP_READ: begin
                            if (pos_cmp < fill_cmp) begin
                                mem_raddr  = AW'(in_pos);
                                idx_next   = CW'(in_pos);
                                state_next = ST_READ_WAIT;
                            end
                        end
                        OP_FIND: begin
                            if (fill_reg != '0) begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                            ok_next   = 1'b1;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_SHIFT_UP: begin
                // entry idx-1 arrives; write it one place up
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = mem_rdata;
                if ((idx_reg - CW'(1)) == CW'(pos_reg)) begin
                    state_next = ST_INS_WR;
                end else begin
                    mem_raddr = AW'(idx_reg - CW'(2));
                    idx_next  = idx_reg - CW'(1);
                end
            end

            ST_INS_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = word_reg;
                fill_next  = fill_reg + CW'(1);
                ok_next    = 1'b1;
                state_next = ST_FINISH;
            end

            ST_READ_WAIT: begin
                rd_next    = mem_rdata;
                ok_next    = 1'b1;
                state_next = ST_FINISH;
                if (op_reg == OP_REMOVE) begin
                    if ((idx_reg + CW'(1)) < fill_reg) begin
                        mem_raddr  = AW'(idx_reg + CW'(1));
                        state_next = ST_SHIFT_DN;
                    end else begin
                        fill_next = fill_reg - CW'(1);
                    end
                end
            end

            ST_SHIFT_DN: begin
                // entry idx+1 arrives; write it one place down
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = mem_rdata;
                if (idx_plus2 < {1'b0, fill_reg}) begin
                    mem_raddr = AW'(idx_plus2);
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_SCAN: begin
                if (mem_rdata == word_reg) begin
                    ok_next    = 1'b1;
                    at_next    = AW'(idx_reg);
                    state_next = ST_FINISH;
                end else if ((idx_reg + CW'(1)) < fill_reg) begin
                    mem_raddr = AW'(idx_reg + CW'(1));
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // hold until the output register frees
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, (fill_reg == '0), COUNT_W'(fill_reg),
                                     AT_W'(at_reg), rd_reg, ok_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        word_reg    <= word_next;
        ok_reg      <= ok_next;
        rd_reg      <= rd_next;
        at_reg      <= at_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the bounded array list engine.
`timescale 1ns / 1ps

module tb;
    import bale_pkg::*;

    // op code that the block leaves unused; it must answer ok 0
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int STALL_CYCLES    = 400;
    localparam int SETTLE_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int LIST_AW         = $clog2(CAPACITY_DEF);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
    } list_request_t;

    typedef struct packed {
        logic               ok;
        logic [WORD_W-1:0]  read_word;
        logic [AT_W-1:0]    found_at;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } list_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    list_request_t pending_reqs[$];
    list_result_t  expected_results[$];
    list_request_t offered;

    // shadow of the list, updated when a request word is accepted
    logic [WORD_W-1:0] list_mem[CAPACITY_DEF];
    int unsigned       list_len = 0;

    // list length as seen while generating stimulus, used to aim positions
    int unsigned       gen_len = 0;
    bit                growing = 1'b1;
    logic [WORD_W-1:0] value_pool[16];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_left    = 0;
    bit          stall_done    = 1'b0;
    int unsigned results_taken = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    bounded_array_list_engine #(
        .CAPACITY(CAPACITY_DEF)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // position[6:0], word[38:7], zero pad
        .s_tuser (s_tuser),   // op[2:0], zero pad
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // ok, read_word, found_at, count, empty_res
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it must produce.
    function automatic list_result_t apply_request(list_request_t r);
        list_result_t res;
        int unsigned  i;
        res = '0;
        case (r.op)
            OP_APPEND: begin
                if (list_len < CAPACITY_DEF) begin
                    list_mem[list_len] = r.word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_INSERT: begin
                if (r.pos <= list_len && list_len < CAPACITY_DEF) begin
                    for (i = list_len; i > r.pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[r.pos[LIST_AW-1:0]] = r.word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_OVERWRITE: begin
                if (r.pos < list_len) begin
                    list_mem[r.pos[LIST_AW-1:0]] = r.word;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r.pos < list_len) begin
                    res.read_word = list_mem[r.pos[LIST_AW-1:0]];
                    for (i = r.pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (r.pos < list_len) begin
                    res.read_word = list_mem[r.pos[LIST_AW-1:0]];
                    res.ok = 1'b1;
                end
            end
            OP_FIND: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == r.word) begin
                        res.ok = 1'b1;
                        res.found_at = i[AT_W-1:0];
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = list_len[COUNT_W-1:0];
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    // Queue one request and track the length it leaves behind.
    task automatic push_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] w);
        list_request_t r;
        r.op = op;
        r.pos = pos;
        r.word = w;
        pending_reqs.push_back(r);
        case (op)
            OP_APPEND: if (gen_len < CAPACITY_DEF) gen_len++;
            OP_INSERT: if (pos <= gen_len && gen_len < CAPACITY_DEF) gen_len++;
            OP_REMOVE: if (pos < gen_len) gen_len--;
            OP_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    // Mostly well-formed requests: grow the list to full, then drain it, with a
    // small pool of values so that finds hit. About one in ten is noise.
    task automatic push_random();
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] w;
        int unsigned       sel;
        if ($urandom_range(99) < 70)
            w = value_pool[$urandom_range(15)];
        else
            w = $urandom;
        if ($urandom_range(99) < 10) begin
            op = OP_W'($urandom_range(7));
            pos = POS_W'($urandom_range(127));
        end else begin
            sel = $urandom_range(99);
            if (growing) begin
                if (sel < 30)      op = OP_APPEND;
                else if (sel < 60) op = OP_INSERT;
                else if (sel < 70) op = OP_OVERWRITE;
                else if (sel < 80) op = OP_READ;
                else if (sel < 90) op = OP_FIND;
                else if (sel < 99) op = OP_REMOVE;
                else               op = OP_CLEAR;
            end else begin
                if (sel < 40)      op = OP_REMOVE;
                else if (sel < 55) op = OP_READ;
                else if (sel < 70) op = OP_FIND;
                else if (sel < 80) op = OP_OVERWRITE;
                else if (sel < 90) op = OP_APPEND;
                else if (sel < 98) op = OP_INSERT;
                else               op = OP_CLEAR;
            end
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(gen_len));
            else
                pos = (gen_len != 0) ? POS_W'($urandom_range(gen_len - 1)) : '0;
        end
        push_req(op, pos, w);
        if (gen_len >= CAPACITY_DEF)
            growing = 1'b0;
        else if (gen_len == 0)
            growing = 1'b1;
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Driver: hold the offered word until taken, then advance or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= {{(S_TUSER_W - OP_W){1'b0}}, offered.op};
                    s_tdata <= {{(S_TDATA_W - POS_W - WORD_W){1'b0}}, offered.word, offered.pos};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, plus one long hold-off that backs up the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!stall_done && results_taken >= 40) begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each taken result word with the oldest expectation.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_taken++;
            if (expected_results.size() == 0) begin
                $error("result word with no request outstanding: 0x%0h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("ok", WORD_W'(want.ok), WORD_W'(m_tdata[0]));
                check_field("read_word", want.read_word, m_tdata[32:1]);
                check_field("found_at", WORD_W'(want.found_at), WORD_W'(m_tdata[38:33]));
                check_field("count", WORD_W'(want.count), WORD_W'(m_tdata[45:39]));
                check_field("empty_res", WORD_W'(want.empty_res), WORD_W'(m_tdata[46]));
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no word moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bounded_array_list_engine regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 16; k++)
            value_pool[k] = $urandom;

        send_idle_pct = 34;
        recv_idle_pct = 46;

        // empty list: every indexed access and find fails
        push_req(OP_READ, 7'd0, 32'h0);
        push_req(OP_REMOVE, 7'd0, 32'h0);
        push_req(OP_OVERWRITE, 7'd0, 32'h1234_5678);
        push_req(OP_FIND, 7'd0, 32'h0);
        push_req(OP_INSERT, 7'd1, 32'h5555_AAAA);
        // fill with extreme values, insert at front, end and middle
        push_req(OP_INSERT, 7'd0, 32'h8000_0000);
        push_req(OP_APPEND, 7'd0, 32'h7FFF_FFFF);
        push_req(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        push_req(OP_APPEND, 7'd0, 32'h0000_0000);
        push_req(OP_INSERT, 7'd4, 32'hFFFF_FFFF);
        push_req(OP_INSERT, 7'd2, 32'hA5A5_5A5A);
        push_req(OP_OVERWRITE, 7'd0, 32'h0F0F_F0F0);
        push_req(OP_READ, 7'd0, 32'h0);
        push_req(OP_READ, 7'd5, 32'h0);
        push_req(OP_READ, 7'd127, 32'h0);
        push_req(OP_INSERT, 7'd64, 32'h1);
        // find with a duplicate value reports the lower index; then a miss
        push_req(OP_FIND, 7'd0, 32'hFFFF_FFFF);
        push_req(OP_FIND, 7'd0, 32'h1357_9BDF);
        push_req(OP_REMOVE, 7'd2, 32'h0);
        push_req(OP_REMOVE, 7'd4, 32'h0);
        push_req(OP_UNUSED, 7'd3, 32'hDEAD_BEEF);
        push_req(OP_CLEAR, 7'd0, 32'h0);
        push_req(OP_READ, 7'd0, 32'h0);
        push_req(OP_CLEAR, 7'd0, 32'h0);

        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            push_random();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0)
            @(posedge aclk);
        send_idle_pct = 46;
        recv_idle_pct = 34;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            push_random();

        while (pending_reqs.size() != 0)
            @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            push_random();

        // drain: every request taken and every result word checked
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("bounded_array_list_engine regression: pass");
        else
            $display("bounded_array_list_engine regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bale_pkg.sv
rtl/bale_ram.sv
rtl/bounded_array_list_engine.sv
sim/tb.sv
